// ===== hw/rtl/hsirgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsirgb_pkg
// Types, constants and the hue ratio table for the HSI to RGB converter.
// ----------------------------------------------------------------------------
package hsirgb_pkg;

    localparam int HUE_STEPS    = 360;
    localparam int SECTOR_STEPS = HUE_STEPS / 3;
    localparam int HALF_SECTOR  = SECTOR_STEPS / 2;

    localparam int HUE_W   = 9;
    localparam int CHAN_W  = 8;
    localparam int D_W     = $clog2(SECTOR_STEPS);
    localparam int FRAC_W  = 16;
    localparam int RATIO_W = 19;
    localparam int NUM_W   = 27;
    localparam int X_W     = 18;
    localparam int Q_W     = 9;

    localparam int CHAN_DIV  = 765;
    localparam int RCP_SHIFT = 28;
    localparam int RCP_W     = 19;
    localparam int RCP_MULT  = (1 << RCP_SHIFT) / CHAN_DIV;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    localparam int     Q30_SHIFT = 30;
    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint COS1_Q30  = 64'sd1073578288;
    localparam longint SIN1_Q30  = 64'sd18739379;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] intensity;
    } t_hsi;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef enum logic [1:0] {
        SECTOR_RG = 2'd0,
        SECTOR_GB = 2'd1,
        SECTOR_BR = 2'd2
    } t_sector;

    typedef logic signed [RATIO_W-1:0] t_ratio;
    typedef logic signed [NUM_W-1:0]   t_num;
    typedef logic [SECTOR_STEPS-1:0][RATIO_W-1:0] t_ratio_rom;

    typedef struct packed {
        logic load_mul;
        logic load_rcp;
        logic load_fix;
    } t_scale_ctl;

    // Q30 product back to Q30, rounded half away from zero
    function automatic longint q30_round(input longint a);
        longint half;
        half = ONE_Q30 >>> 1;
        if (a >= 0) begin
            return (a + half) >>> Q30_SHIFT;
        end
        return -((-a + half) >>> Q30_SHIFT);
    endfunction

    // cos(d)/cos(60-d) in Q16, cosine column built by one-degree rotations
    function automatic t_ratio_rom build_ratio_rom();
        longint     cosv [SECTOR_STEPS];
        longint     c;
        longint     s;
        longint     nc;
        longint     ns;
        longint     den;
        longint     mag;
        longint     quo;
        longint     rmd;
        int         off;
        logic       neg;
        t_ratio_rom rom;
        c   = ONE_Q30;
        s   = 0;
        rom = '0;
        for (int k = 0; k < SECTOR_STEPS; k++) begin
            cosv[k] = c;
            nc = q30_round(c * COS1_Q30 - s * SIN1_Q30);
            ns = q30_round(s * COS1_Q30 + c * SIN1_Q30);
            c  = nc;
            s  = ns;
        end
        for (int k = 0; k < SECTOR_STEPS; k++) begin
            off = (k > HALF_SECTOR) ? k - HALF_SECTOR : HALF_SECTOR - k;
            den = cosv[off];
            if (den <= 0) begin
                den = 1;
            end
            neg = (cosv[k] < 0);
            mag = ((neg ? -cosv[k] : cosv[k]) <<< FRAC_W) + (den >>> 1);
            quo = 0;
            rmd = 0;
            for (int b = 62; b >= 0; b--) begin
                rmd = (rmd <<< 1) | ((mag >>> b) & 64'sd1);
                quo = quo <<< 1;
                if (rmd >= den) begin
                    rmd = rmd - den;
                    quo = quo | 64'sd1;
                end
            end
            rom[k] = RATIO_W'(neg ? -quo : quo);
        end
        return rom;
    endfunction

    localparam t_ratio_rom RATIO_ROM = build_ratio_rom();

endpackage

// ===== hw/rtl/hsirgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsirgb_scale
// Scales one channel numerator by intensity and divides by 765 * 2^16.
// Three register stages: product, reciprocal quotient, corrected level.
// ----------------------------------------------------------------------------
module hsirgb_scale (
    input  logic                      i_clk,
    input  hsirgb_pkg::t_scale_ctl    i_ctl,
    input  logic [hsirgb_pkg::CHAN_W-1:0] i_intensity,
    input  hsirgb_pkg::t_num          i_num,
    output logic [hsirgb_pkg::CHAN_W-1:0] o_level
);
    import hsirgb_pkg::*;

    localparam int PROD_W = CHAN_W + NUM_W - 1;
    localparam int RP_W   = X_W + RCP_W;

    logic [PROD_W-1:0]  prod;
    logic [X_W-1:0]     n_x;
    logic [X_W-1:0]     r_x;
    logic [RP_W-1:0]    rcp_prod;
    logic [Q_W-1:0]     n_q;
    logic [Q_W-1:0]     r_q;
    logic [X_W-1:0]     r_x_q;
    logic [X_W-1:0]     rmd;
    logic [Q_W-1:0]     q_fix;
    logic [CHAN_W-1:0]  n_level;
    logic [CHAN_W-1:0]  r_level;

    always_comb begin
        if (i_num > 0) begin
            prod = PROD_W'(i_intensity) * PROD_W'(i_num[NUM_W-2:0]);
        end else begin
            prod = '0;
        end
        n_x = prod[FRAC_W +: X_W];
    end

    always_comb begin
        rcp_prod = RP_W'(r_x) * RP_W'(RCP_MULT);
        n_q      = rcp_prod[RCP_SHIFT +: Q_W];
    end

    // reciprocal quotient is low by at most one
    always_comb begin
        rmd   = r_x_q - X_W'(X_W'(r_q) * X_W'(CHAN_DIV));
        q_fix = r_q + Q_W'(rmd >= X_W'(CHAN_DIV));
        if (q_fix > Q_W'(CHAN_MAX)) begin
            n_level = CHAN_MAX;
        end else begin
            n_level = q_fix[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_mul) begin
            r_x <= n_x;
        end
        if (i_ctl.load_rcp) begin
            r_q   <= n_q;
            r_x_q <= r_x;
        end
        if (i_ctl.load_fix) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

// ===== hw/rtl/hsi_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsi_to_rgb_converter
// HSI to 8-bit RGB conversion, six register stages.
// Throughput: one transfer per cycle; each stage holds under backpressure.
// Reset: synchronous active low, clears all stage valid bits.
// ----------------------------------------------------------------------------
module hsi_to_rgb_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hsirgb_pkg::t_hsi  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hsirgb_pkg::t_rgb  o_out_data
);
    import hsirgb_pkg::*;

    localparam int STAGES  = 6;
    localparam int CH_LOW  = 0;
    localparam int CH_MID  = 1;
    localparam int CH_REST = 2;
    localparam int SW      = NUM_W + 1;

    localparam logic signed [SW-1:0] FULL_Q = $signed(SW'(CHAN_MAX) << FRAC_W);

    logic [STAGES:1]   ld;
    logic [STAGES:1]   r_valid;

    logic [HUE_W-1:0]  hue_mod;
    t_sector           n_s1_sector;
    logic [D_W-1:0]    n_s1_d;

    t_sector           r_s1_sector;
    logic [D_W-1:0]    r_s1_d;
    logic [CHAN_W-1:0] r_s1_sat;
    logic [CHAN_W-1:0] r_s1_inten;

    t_sector           r_s2_sector;
    t_ratio            r_s2_ratio;
    logic [CHAN_W-1:0] r_s2_sat;
    logic [CHAN_W-1:0] r_s2_inten;

    logic signed [SW-1:0] sr;
    logic signed [SW-1:0] sat_q;
    t_num              n_s3_num [3];
    t_num              r_s3_num [3];
    t_sector           r_s3_sector;
    logic              r_s3_zero;
    logic [CHAN_W-1:0] r_s3_inten;

    t_sector           r_s4_sector;
    logic              r_s4_zero;
    logic [CHAN_W-1:0] r_s4_inten;
    t_sector           r_s5_sector;
    logic              r_s5_zero;
    logic [CHAN_W-1:0] r_s5_inten;
    t_sector           r_s6_sector;
    logic              r_s6_zero;
    logic [CHAN_W-1:0] r_s6_inten;

    t_scale_ctl        scale_ctl;
    logic [CHAN_W-1:0] level [3];

    always_comb begin
        ld[STAGES] = !r_valid[STAGES] || i_out_ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            ld[k] = !r_valid[k] || ld[k+1];
        end
    end

    assign o_in_ready  = ld[1];
    assign o_out_valid = r_valid[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (ld[1]) begin
                r_valid[1] <= i_in_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (ld[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // stage 1: hue reduction and sector split
    always_comb begin
        if (i_in_data.hue >= HUE_W'(HUE_STEPS)) begin
            hue_mod = i_in_data.hue - HUE_W'(HUE_STEPS);
        end else begin
            hue_mod = i_in_data.hue;
        end
        if (hue_mod < HUE_W'(SECTOR_STEPS)) begin
            n_s1_sector = SECTOR_RG;
            n_s1_d      = D_W'(hue_mod);
        end else if (hue_mod < HUE_W'(2 * SECTOR_STEPS)) begin
            n_s1_sector = SECTOR_GB;
            n_s1_d      = D_W'(hue_mod - HUE_W'(SECTOR_STEPS));
        end else begin
            n_s1_sector = SECTOR_BR;
            n_s1_d      = D_W'(hue_mod - HUE_W'(2 * SECTOR_STEPS));
        end
    end

    // stage 3: channel numerators in Q16
    always_comb begin
        sr    = $signed({1'b0, r_s2_sat}) * r_s2_ratio;
        sat_q = $signed(SW'(r_s2_sat) << FRAC_W);
        n_s3_num[CH_LOW]  = NUM_W'(FULL_Q - sat_q);
        n_s3_num[CH_MID]  = NUM_W'(FULL_Q + sr);
        n_s3_num[CH_REST] = NUM_W'(FULL_Q + sat_q - sr);
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_s1_sector <= n_s1_sector;
            r_s1_d      <= n_s1_d;
            r_s1_sat    <= i_in_data.saturation;
            r_s1_inten  <= i_in_data.intensity;
        end
        if (ld[2]) begin
            r_s2_sector <= r_s1_sector;
            r_s2_ratio  <= $signed(RATIO_ROM[r_s1_d]);
            r_s2_sat    <= r_s1_sat;
            r_s2_inten  <= r_s1_inten;
        end
        if (ld[3]) begin
            r_s3_num    <= n_s3_num;
            r_s3_sector <= r_s2_sector;
            r_s3_zero   <= (r_s2_sat == '0);
            r_s3_inten  <= r_s2_inten;
        end
        if (ld[4]) begin
            r_s4_sector <= r_s3_sector;
            r_s4_zero   <= r_s3_zero;
            r_s4_inten  <= r_s3_inten;
        end
        if (ld[5]) begin
            r_s5_sector <= r_s4_sector;
            r_s5_zero   <= r_s4_zero;
            r_s5_inten  <= r_s4_inten;
        end
        if (ld[6]) begin
            r_s6_sector <= r_s5_sector;
            r_s6_zero   <= r_s5_zero;
            r_s6_inten  <= r_s5_inten;
        end
    end

    // stages 4 to 6: per-channel scale and divide
    assign scale_ctl = '{load_mul: ld[4], load_rcp: ld[5], load_fix: ld[6]};

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        hsirgb_scale u_scale (
            .i_clk       (i_clk),
            .i_ctl       (scale_ctl),
            .i_intensity (r_s3_inten),
            .i_num       (r_s3_num[ch]),
            .o_level     (level[ch])
        );
    end

    always_comb begin
        if (r_s6_zero) begin
            o_out_data = '{red: r_s6_inten, green: r_s6_inten, blue: r_s6_inten};
        end else begin
            unique case (r_s6_sector)
                SECTOR_RG: o_out_data = '{red:   level[CH_MID],
                                          green: level[CH_REST],
                                          blue:  level[CH_LOW]};
                SECTOR_GB: o_out_data = '{red:   level[CH_LOW],
                                          green: level[CH_MID],
                                          blue:  level[CH_REST]};
                SECTOR_BR: o_out_data = '{red:   level[CH_REST],
                                          green: level[CH_LOW],
                                          blue:  level[CH_MID]};
                default:   o_out_data = '0;
            endcase
        end
    end

endmodule

// ===== hw/rtl/hsirgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsirgb_checker
// Port-level checks for the HSI to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsirgb_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input hsirgb_pkg::t_rgb o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // empty or draining output never blocks input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input blocked with output free");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an accepted transfer reaches the output when the sink keeps up
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind hsi_to_rgb_converter hsirgb_checker u_hsirgb_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hsi_to_rgb_converter. A short directed set covers
// the field extremes, all three hue sectors, hue wrap past 359, zero
// saturation and full-scale saturation. About two thousand random triples
// follow, under random input gaps and output stalls. Each transfer is
// predicted with a fixed-point model that holds its own cosine ratio table,
// and each result is checked in order against the expected queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import hsirgb_pkg::*;

    localparam int    RANDOM_ITEMS = 1950;
    localparam int    TAIL_CYCLES  = 20;
    localparam int    REPORT_MAX   = 10;
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_COS1    = 64'sd1073578288;
    localparam longint Q30_SIN1    = 64'sd18739379;
    localparam longint Q16_ONE     = 64'sd65536;
    localparam longint FULL_SCALE  = 64'sd255;

    class rgb_scoreboard;
        longint cos_ratio [SECTOR_STEPS];
        t_rgb   rgb_expected [$];
        t_hsi   hsi_sent [$];
        int     checked;
        int     errors;

        function longint div_round_away(longint a, longint b);
            if (a >= 0) begin
                return (a + b / 2) / b;
            end
            return -((-a + b / 2) / b);
        endfunction

        function new();
            longint cosq [SECTOR_STEPS];
            longint c;
            longint s;
            longint nc;
            longint ns;
            longint den;
            int     off;
            checked = 0;
            errors  = 0;
            c = Q30_ONE;
            s = 0;
            for (int k = 0; k < SECTOR_STEPS; k++) begin
                cosq[k] = c;
                nc = div_round_away(c * Q30_COS1 - s * Q30_SIN1, Q30_ONE);
                ns = div_round_away(s * Q30_COS1 + c * Q30_SIN1, Q30_ONE);
                c  = nc;
                s  = ns;
            end
            for (int k = 0; k < SECTOR_STEPS; k++) begin
                off = 60 - k;
                if (off < 0) begin
                    off = -off;
                end
                den = cosq[off];
                if (den <= 0) begin
                    den = 1;
                end
                cos_ratio[k] = div_round_away(cosq[k] * Q16_ONE, den);
            end
        endfunction

        // intensity times channel fraction, truncated and clamped
        function logic [7:0] level(longint inten, longint num);
            longint v;
            if (num <= 0) begin
                return 8'd0;
            end
            v = (inten * num) / (3 * FULL_SCALE * Q16_ONE);
            if (v > 255) begin
                v = 255;
            end
            return v[7:0];
        endfunction

        function t_rgb predict_rgb(t_hsi x);
            int         h;
            int         d;
            longint     sat;
            longint     inten;
            longint     r;
            logic [7:0] v_lo;
            logic [7:0] v_mid;
            logic [7:0] v_hi;
            t_rgb       y;
            h     = int'(x.hue) % HUE_STEPS;
            sat   = longint'(x.saturation);
            inten = longint'(x.intensity);
            if (sat == 0) begin
                y.red   = x.intensity;
                y.green = x.intensity;
                y.blue  = x.intensity;
                return y;
            end
            d     = h % SECTOR_STEPS;
            r     = cos_ratio[d];
            v_lo  = level(inten, (FULL_SCALE - sat) * Q16_ONE);
            v_mid = level(inten, FULL_SCALE * Q16_ONE + sat * r);
            v_hi  = level(inten, Q16_ONE * (FULL_SCALE + sat) - sat * r);
            case (t_sector'(h / SECTOR_STEPS))
                SECTOR_RG: begin
                    y.red = v_mid; y.green = v_hi;  y.blue = v_lo;
                end
                SECTOR_GB: begin
                    y.red = v_lo;  y.green = v_mid; y.blue = v_hi;
                end
                default: begin
                    y.red = v_hi;  y.green = v_lo;  y.blue = v_mid;
                end
            endcase
            return y;
        endfunction

        function void note_hsi(t_hsi x);
            rgb_expected.push_back(predict_rgb(x));
            hsi_sent.push_back(x);
        endfunction

        function void check_rgb(t_rgb y);
            t_rgb exp_rgb;
            t_hsi src;
            if (rgb_expected.size() == 0) begin
                if (errors < REPORT_MAX) begin
                    $display("ERROR: unexpected result r=%0d g=%0d b=%0d",
                             y.red, y.green, y.blue);
                end
                errors++;
                return;
            end
            exp_rgb = rgb_expected.pop_front();
            src     = hsi_sent.pop_front();
            checked++;
            if (y.red !== exp_rgb.red || y.green !== exp_rgb.green ||
                y.blue !== exp_rgb.blue) begin
                if (errors < REPORT_MAX) begin
                    $display("ERROR: h=%0d s=%0d i=%0d exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                             src.hue, src.saturation, src.intensity,
                             exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                             y.red, y.green, y.blue);
                end
                errors++;
            end
        endfunction

        function int pending();
            return rgb_expected.size();
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_hsi in_data   = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_rgb out_data;

    logic steady    = 1'b0;
    int   zero_sat  = 0;
    int   wrapped   = 0;

    rgb_scoreboard board = new();

    hsi_to_rgb_converter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int p;
        if (steady) begin
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 60) begin
            return 0;
        end else if (p < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_hsi(input logic [8:0] h, input logic [7:0] s,
                            input logic [7:0] i);
        t_hsi item;
        int   gap;
        item.hue        = h;
        item.saturation = s;
        item.intensity  = i;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_hsi(item);
        if (s == 8'd0) begin
            zero_sat++;
        end
        if (h >= 9'(HUE_STEPS)) begin
            wrapped++;
        end
    endtask

    // output backpressure
    initial begin
        wait (rst_n);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (!steady) begin
                out_ready <= 1'b0;
                if ($urandom_range(0, 9) < 8) begin
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end else begin
                    repeat ($urandom_range(8, 40)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            board.check_rgb(out_data);
        end
    end

    initial begin
        logic [7:0] s;
        logic [7:0] i;
        int         p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero saturation
        send_hsi(9'd0,   8'd0,   8'd0);
        send_hsi(9'd200, 8'd0,   8'd255);
        send_hsi(9'd511, 8'd0,   8'd128);
        // full scale across the sectors and their edges
        send_hsi(9'd0,   8'd255, 8'd255);
        send_hsi(9'd59,  8'd255, 8'd200);
        send_hsi(9'd60,  8'd255, 8'd255);
        send_hsi(9'd61,  8'd255, 8'd200);
        send_hsi(9'd119, 8'd255, 8'd255);
        send_hsi(9'd120, 8'd255, 8'd255);
        send_hsi(9'd180, 8'd255, 8'd255);
        send_hsi(9'd239, 8'd255, 8'd255);
        send_hsi(9'd240, 8'd255, 8'd255);
        send_hsi(9'd300, 8'd255, 8'd255);
        send_hsi(9'd359, 8'd255, 8'd255);
        // hue wrap
        send_hsi(9'd360, 8'd255, 8'd255);
        send_hsi(9'd479, 8'd170, 8'd255);
        send_hsi(9'd480, 8'd255, 8'd255);
        send_hsi(9'd511, 8'd255, 8'd255);
        // small saturation and intensity
        send_hsi(9'd30,  8'd1,   8'd255);
        send_hsi(9'd90,  8'd128, 8'd1);
        send_hsi(9'd45,  8'd200, 8'd0);
        send_hsi(9'd270, 8'd85,  8'd170);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            p = $urandom_range(0, 99);
            s = (p < 10) ? 8'd0 : (p < 20) ? 8'd255 : 8'($urandom_range(0, 255));
            p = $urandom_range(0, 99);
            i = (p < 10) ? 8'd255 : (p < 15) ? 8'd0 : 8'($urandom_range(0, 255));
            send_hsi(9'($urandom_range(0, 511)), s, i);
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d conversions checked: %0d with zero saturation, %0d with hue past 359",
                 board.checked, zero_sat, wrapped);
        $display("%0d errors", board.errors);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
